// ===== hw/rtl/xsa_pkg.sv =====
// shared types and constants for the subtract / ascii-adjust flag alu
// no dependencies; used by xsa_alu and x86_sub_adjust_flag_alu
package xsa_pkg;

   typedef enum logic [2:0] {
      OP_SUB = 3'd0,
      OP_SBB = 3'd1,
      OP_INC = 3'd2,
      OP_DEC = 3'd3,
      OP_AAA = 3'd4,
      OP_AAS = 3'd5,
      OP_AAD = 3'd6,
      OP_AAM = 3'd7
   } op_type;

   localparam logic [3:0]  NIBBLE_MAX_BCD = 4'd9;
   localparam logic [7:0]  ADJUST_STEP    = 8'd6;
   localparam logic [7:0]  DECIMAL_BASE   = 8'd10;
   // floor(x / 10) == (x * 205) >> 11 for every byte value
   localparam logic [7:0]  TEN_RECIP      = 8'd205;
   localparam int          TEN_SHIFT      = 11;

   typedef struct packed {
      op_type      op;
      logic        is_word;
      logic [15:0] left_operand;
      logic [15:0] right_operand;
   } req_type;

   typedef struct packed {
      logic [15:0] result_value;
      logic        carry_flag;
      logic        parity_flag;
      logic        aux_flag;
      logic        zero_flag;
      logic        sign_flag;
      logic        overflow_flag;
   } rsp_type;

   typedef struct packed {
      logic cf;
      logic pf;
      logic af;
      logic zf;
      logic sf;
      logic of;
   } flags_type;

endpackage

// ===== hw/rtl/x86_sub_adjust_flag_alu.sv =====
// top level: input register, alu datapath, result register and flags register
// depends on xsa_pkg and xsa_alu
//
//   channel  ports                          payload
//   req      req_valid req_ready req_data   req_type (op, is_word, operands)
//   rsp      rsp_valid rsp_ready rsp_data   rsp_type (result, six flags)
//
// an item is held first in the input register and then in the result
// register; one item per cycle sustained while rsp_ready is high
// the flags register updates as an item moves into the result register,
// so sbb / aaa / aas see the flags of the item just before them
// reset clears both valid bits and the flags; a stalled rsp holds the
// result register and backs up into the input register, then req_ready
module x86_sub_adjust_flag_alu
   import xsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      in_valid_ff;
   req_type   in_data_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_data_ff;
   flags_type flags_ff;
   flags_type flags_in;
   rsp_type   alu_rsp;
   logic      out_free;
   logic      advance;
   logic      in_valid_in;

   xsa_alu u_alu (
      .req       (in_data_ff),
      .flags_old (flags_ff),
      .rsp       (alu_rsp),
      .flags_new (flags_in)
   );

   assign out_free     = !out_valid_ff || rsp_ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            flags_ff <= flags_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= alu_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== hw/rtl/xsa_alu.sv =====
// combinational datapath: result and flags for one operation
// depends on xsa_pkg
module xsa_alu
   import xsa_pkg::*;
(
   input  req_type   req,
   input  flags_type flags_old,
   output rsp_type   rsp,
   output flags_type flags_new
);

   logic [15:0] mask;
   logic [15:0] a_m;
   logic [15:0] b_m;
   logic        borrow_in;
   logic [16:0] diff;
   logic [4:0]  nib_diff;
   logic [15:0] res;
   logic        top_a;
   logic        top_b;
   logic        top_r;
   logic [7:0]  al;
   logic [7:0]  ah;
   logic        adj;
   logic [7:0]  al_adj;
   logic [7:0]  ah_adj;
   logic [7:0]  aad_al;
   logic [15:0] aam_prod;
   logic [7:0]  aam_q;
   logic [7:0]  aam_r;
   logic        byte_flags;
   logic        set_szp;
   flags_type   f;

   assign mask      = req.is_word ? 16'hFFFF : 16'h00FF;
   assign a_m       = req.left_operand & mask;
   assign b_m       = req.right_operand & mask;
   assign borrow_in = (req.op == OP_SBB) ? flags_old.cf : 1'b0;
   assign diff      = {1'b0, a_m} - {1'b0, b_m} - {16'd0, borrow_in};
   assign nib_diff  = {1'b0, a_m[3:0]} - {1'b0, b_m[3:0]} - {4'd0, borrow_in};

   assign al = req.left_operand[7:0];
   assign ah = req.left_operand[15:8];
   assign adj = (al[3:0] > NIBBLE_MAX_BCD) || flags_old.af;
   assign al_adj = (req.op == OP_AAA) ? al + ADJUST_STEP : al - ADJUST_STEP;
   assign ah_adj = (req.op == OP_AAA) ? ah + 8'd1 : ah - 8'd1;

   // ah * 10 + al, truncated to a byte
   assign aad_al   = {ah[4:0], 3'b000} + {ah[6:0], 1'b0} + al;
   assign aam_prod = {8'd0, al} * {8'd0, TEN_RECIP};
   assign aam_q    = {3'b000, aam_prod[TEN_SHIFT +: 5]};
   assign aam_r    = al - aam_q * DECIMAL_BASE;

   assign top_a = req.is_word ? a_m[15] : a_m[7];
   assign top_b = req.is_word ? b_m[15] : b_m[7];

   always_comb begin
      f          = flags_old;
      res        = '0;
      byte_flags = 1'b0;
      set_szp    = 1'b1;
      case (req.op)
         OP_SUB, OP_SBB: begin
            res  = diff[15:0] & mask;
            f.cf = diff[16];
            f.af = nib_diff[4];
         end
         OP_INC: begin
            res  = (a_m + 16'd1) & mask;
            f.af = (a_m[3:0] == 4'hF);
         end
         OP_DEC: begin
            res  = (a_m - 16'd1) & mask;
            f.af = (a_m[3:0] == 4'h0);
         end
         OP_AAA, OP_AAS: begin
            res     = adj ? {ah_adj, 4'h0, al_adj[3:0]} : {ah, 4'h0, al[3:0]};
            f.cf    = adj;
            f.af    = adj;
            set_szp = 1'b0;
         end
         OP_AAD: begin
            res        = {8'h00, aad_al};
            byte_flags = 1'b1;
         end
         default: begin
            res        = {aam_q, aam_r};
            byte_flags = 1'b1;
         end
      endcase

      top_r = (req.is_word && !byte_flags) ? res[15] : res[7];

      // overflow for the arithmetic ops, kept for the adjust ops
      case (req.op)
         OP_SUB, OP_SBB: f.of = (top_a ^ top_b) & (top_a ^ top_r);
         OP_INC:         f.of = (res == (req.is_word ? 16'h8000 : 16'h0080));
         OP_DEC:         f.of = (a_m == (req.is_word ? 16'h8000 : 16'h0080));
         default:        f.of = f.of;
      endcase

      if (set_szp) begin
         if (req.is_word && !byte_flags) begin
            f.zf = (res == 16'd0);
         end else begin
            f.zf = (res[7:0] == 8'd0);
         end
         f.sf = top_r;
         f.pf = ~^res[7:0];
      end
   end

   assign flags_new = f;

   always_comb begin
      rsp.result_value  = res;
      rsp.carry_flag    = f.cf;
      rsp.parity_flag   = f.pf;
      rsp.aux_flag      = f.af;
      rsp.zero_flag     = f.zf;
      rsp.sign_flag     = f.sf;
      rsp.overflow_flag = f.of;
   end

endmodule
